// ===== rtl/core/slot_pool_alloc_release_enum_defines.svh =====
// ----------------------------------------------------------------------------
// Slot pool assertion macros
// Shared concurrent assertion forms for the slot pool checker.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_ALLOC_RELEASE_ENUM_DEFINES_SVH
`define SLOT_POOL_ALLOC_RELEASE_ENUM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot pool package
// Types, codes and constants shared by the slot pool modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

    // Default pool size and the fixed width of a reported slot number.
    localparam int SLOTS_DEF = 64;
    localparam int SLOT_W    = 6;

    // The free-slot search looks at the pool in groups of this many slots.
    localparam int GROUP_W = 8;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ENUM    = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // One input item.
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] model_id;
        logic signed [31:0] kind_id;
        logic [31:0]        pos_x_bits;
        logic [31:0]        pos_y_bits;
        logic [31:0]        pos_z_bits;
        logic               pinned;
        logic [7:0]         release_index;
        logic [7:0]         player_id;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic signed [31:0] out_model;
        logic signed [31:0] out_kind;
        logic [31:0]        out_x_bits;
        logic [31:0]        out_y_bits;
        logic [31:0]        out_z_bits;
        logic               to_everyone;
        logic [7:0]         recipient;
        logic               last;
    } t_out_item;

    // One stored entry; the pinned bit separates pinned from dynamic marks.
    typedef struct packed {
        logic signed [31:0] model;
        logic signed [31:0] kind;
        logic [31:0]        x_bits;
        logic [31:0]        y_bits;
        logic [31:0]        z_bits;
        logic               pinned;
    } t_entry;

    // Answer of the free-slot search.
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] slot;
    } t_find_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/spa_entry_mem.sv =====
// ----------------------------------------------------------------------------
// Slot pool entry memory
// One write port and one registered read port holding the entry contents.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_entry_mem #(
    parameter int SLOTS = spa_pkg::SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_waddr,
    input  wire spa_pkg::t_entry               i_wdata,
    input  wire logic                          i_re,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_raddr,
    output spa_pkg::t_entry                    o_rdata
);

    spa_pkg::t_entry r_mem [0:SLOTS-1];
    spa_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/spa_free_find.sv =====
// ----------------------------------------------------------------------------
// Slot pool free-slot search
// Two-stage registered priority search for the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_free_find #(
    parameter int SLOTS = spa_pkg::SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SLOTS-1:0] i_occ,
    output spa_pkg::t_find_rsp    o_rsp
);

    localparam int GROUP = spa_pkg::GROUP_W;
    localparam int NGRP  = (SLOTS + GROUP - 1) / GROUP;
    localparam int PAD   = NGRP * GROUP;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int BIT_W = $clog2(GROUP);

    logic [PAD-1:0]            free_pad;
    logic [NGRP-1:0]           grp_any;
    logic [GRP_W-1:0]          grp_sel;
    logic [BIT_W-1:0]          bit_sel;
    logic [GRP_W-1:0]          r_grp;
    logic [GROUP-1:0]          r_bits;
    logic                      r_s1;
    logic                      r_done;
    logic [spa_pkg::SLOT_W-1:0] r_slot;

    // Free map, padded with occupied slots up to a whole group.
    always_comb begin
        free_pad             = '0;
        free_pad[SLOTS-1:0]  = ~i_occ;
    end

    // First stage: lowest group that has a free slot.
    always_comb begin
        grp_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            grp_any[g] = |free_pad[g*GROUP +: GROUP];
            if (grp_any[g]) begin
                grp_sel = GRP_W'(g);
            end
        end
    end

    // Second stage: lowest free slot inside the chosen group.
    always_comb begin
        bit_sel = '0;
        for (int b = GROUP - 1; b >= 0; b--) begin
            if (r_bits[b]) begin
                bit_sel = BIT_W'(b);
            end
        end
    end

    // Stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_done <= r_s1;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_grp  <= grp_sel;
            r_bits <= free_pad[grp_sel*GROUP +: GROUP];
        end
        if (r_s1) begin
            r_slot <= spa_pkg::SLOT_W'({r_grp, bit_sel});
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.slot = r_slot;

endmodule

`default_nettype wire

// ===== rtl/core/slot_pool_alloc_release_enum.sv =====
// ----------------------------------------------------------------------------
// Slot pool with allocate, release and enumerate
// A pool of SLOTS entries; allocate takes the lowest free slot, release
// frees a dynamic entry, enumerate reports every occupied slot in order.
// ----------------------------------------------------------------------------
//
//  Channel  Valid    Stall    Payload   Transfer
//  -------  -------  -------  --------  ------------------------------
//  input    i_valid  o_stall  i_data    i_valid high and o_stall low
//  output   o_valid  i_stall  o_data    o_valid high and i_stall low
//
//  Allocate runs the two-stage free-slot search, the memory write and the
//  output register load. Release does a memory read of the pinned bit,
//  the check and the output load. Enumerate takes the item, then scans
//  the slots in order: a free slot is passed over, and each occupied slot
//  goes through memory read, result build and output load; the scan ends
//  at the last occupied slot. Reset is synchronous and clears the
//  occupancy map and the count. A stalled result waits in the output
//  register, and the next item is taken as soon as the sequencer is idle.
//
`default_nettype none

module slot_pool_alloc_release_enum #(
    parameter int SLOTS = spa_pkg::SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire spa_pkg::t_in_item i_data,
    output logic                   o_stall,
    output logic                   o_valid,
    output spa_pkg::t_out_item     o_data,
    input  wire logic              i_stall
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_REL  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_ERD  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_ret, n_ret;
    spa_pkg::t_in_item  r_in, n_in;
    logic [SLOTS-1:0]   r_occ, n_occ;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_scan, n_scan;
    logic [CNT_W-1:0]   r_left, n_left;
    spa_pkg::t_out_item r_res, n_res;
    logic               r_ovalid, n_ovalid;
    spa_pkg::t_out_item r_out, n_out;

    logic               find_start;
    spa_pkg::t_find_rsp find_rsp;
    logic [IDX_W-1:0]   find_slot;
    logic [IDX_W-1:0]   rel_idx;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    spa_pkg::t_entry    mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    spa_pkg::t_entry    mem_rdata;
    logic               enum_last;

    // Assemble one result item.
    function automatic spa_pkg::t_out_item f_result(
        input logic [1:0]                 status,
        input logic [spa_pkg::SLOT_W-1:0] slot,
        input spa_pkg::t_entry            entry,
        input logic                       to_all,
        input logic [7:0]                 rcpt,
        input logic                       last
    );
        spa_pkg::t_out_item res;
        res.status      = status;
        res.slot        = slot;
        res.out_model   = entry.model;
        res.out_kind    = entry.kind;
        res.out_x_bits  = entry.x_bits;
        res.out_y_bits  = entry.y_bits;
        res.out_z_bits  = entry.z_bits;
        res.to_everyone = to_all;
        res.recipient   = rcpt;
        res.last        = last;
        return res;
    endfunction

    // Entry memory.
    spa_entry_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Lowest free slot search.
    spa_free_find #(
        .SLOTS (SLOTS)
    ) u_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (find_start),
        .i_occ   (r_occ),
        .o_rsp   (find_rsp)
    );

    assign find_slot = find_rsp.slot[IDX_W-1:0];
    assign rel_idx   = r_in.release_index[IDX_W-1:0];
    assign enum_last = (r_left == CNT_W'(1));

    // New entry contents come from the held input item.
    always_comb begin
        mem_wdata.model  = r_in.model_id;
        mem_wdata.kind   = r_in.kind_id;
        mem_wdata.x_bits = r_in.pos_x_bits;
        mem_wdata.y_bits = r_in.pos_y_bits;
        mem_wdata.z_bits = r_in.pos_z_bits;
        mem_wdata.pinned = r_in.pinned;
    end

    // Sequencer and output register.
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_in       = r_in;
        n_occ      = r_occ;
        n_count    = r_count;
        n_scan     = r_scan;
        n_left     = r_left;
        n_res      = r_res;
        n_ovalid   = r_ovalid;
        n_out      = r_out;
        find_start = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = find_slot;
        mem_re     = 1'b0;
        mem_raddr  = r_scan;

        // The held result leaves on a transfer.
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in = i_data;
                    case (i_data.operation)
                        spa_pkg::OP_ALLOC: begin
                            if (r_count >= CNT_W'(SLOTS)) begin
                                n_res   = f_result(spa_pkg::ST_FULL, '0, '0, 1'b0, 8'd0,
                                                   1'b1);
                                n_ret   = S_IDLE;
                                n_state = S_EMIT;
                            end else begin
                                find_start = 1'b1;
                                n_state    = S_FIND;
                            end
                        end
                        spa_pkg::OP_RELEASE: begin
                            if (i_data.release_index >= 8'(SLOTS)) begin
                                n_res   = f_result(spa_pkg::ST_REFUSED,
                                                   i_data.release_index[spa_pkg::SLOT_W-1:0],
                                                   '0, 1'b0, 8'd0, 1'b1);
                                n_ret   = S_IDLE;
                                n_state = S_EMIT;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = i_data.release_index[IDX_W-1:0];
                                n_state   = S_REL;
                            end
                        end
                        spa_pkg::OP_ENUM: begin
                            if (r_count != '0) begin
                                n_scan  = '0;
                                n_left  = r_count;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (find_rsp.done) begin
                    mem_we             = 1'b1;
                    n_occ[find_slot]   = 1'b1;
                    n_count            = r_count + 1'b1;
                    n_res              = f_result(spa_pkg::ST_DONE,
                                                  spa_pkg::SLOT_W'(find_slot),
                                                  mem_wdata, 1'b1, 8'd0, 1'b1);
                    n_ret              = S_IDLE;
                    n_state            = S_EMIT;
                end
            end
            S_REL: begin
                // Only an occupied dynamic entry may be freed.
                if (r_occ[rel_idx] && !mem_rdata.pinned) begin
                    n_occ[rel_idx] = 1'b0;
                    n_count        = r_count - 1'b1;
                    n_res          = f_result(spa_pkg::ST_DONE,
                                              r_in.release_index[spa_pkg::SLOT_W-1:0],
                                              '0, 1'b1, 8'd0, 1'b1);
                end else begin
                    n_res          = f_result(spa_pkg::ST_REFUSED,
                                              r_in.release_index[spa_pkg::SLOT_W-1:0],
                                              '0, 1'b0, 8'd0, 1'b1);
                end
                n_ret   = S_IDLE;
                n_state = S_EMIT;
            end
            S_SCAN: begin
                if (r_occ[r_scan]) begin
                    mem_re  = 1'b1;
                    n_state = S_ERD;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_ERD: begin
                n_res   = f_result(spa_pkg::ST_DONE, spa_pkg::SLOT_W'(r_scan), mem_rdata,
                                   1'b0, r_in.player_id, enum_last);
                n_left  = r_left - 1'b1;
                n_scan  = r_scan + 1'b1;
                n_ret   = enum_last ? S_IDLE : S_SCAN;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_occ    <= '0;
            r_count  <= '0;
            r_scan   <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_occ    <= n_occ;
            r_count  <= n_count;
            r_scan   <= n_scan;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/spa_checker.sv =====
// ----------------------------------------------------------------------------
// Slot pool port checker
// Watches the slot pool ports and flags results or handshakes out of rule.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slot_pool_alloc_release_enum_defines.svh"

module spa_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire spa_pkg::t_in_item  i_data,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire spa_pkg::t_out_item o_data,
    input wire logic               i_stall
);

    // A stalled result stays offered and unchanged.
    `SPA_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data), "result changed while stalled")

    // Failed commands are single results addressed to nobody.
    `SPA_ASSERT_NOW(a_fail_form, o_valid && (o_data.status != spa_pkg::ST_DONE), o_data.last && !o_data.to_everyone, "failed result not final or broadcast")

    // Broadcasts come only from allocate and release and end their command.
    `SPA_ASSERT_NOW(a_bcast_form, o_valid && o_data.to_everyone, o_data.last && (o_data.status == spa_pkg::ST_DONE) && (o_data.recipient == 8'd0), "broadcast result malformed")

    // Allocate and release always keep the sequencer busy afterwards.
    `SPA_ASSERT_NEXT(a_cmd_busy, i_valid && !o_stall && ((i_data.operation == spa_pkg::OP_ALLOC) || (i_data.operation == spa_pkg::OP_RELEASE)), o_stall, "command transfer did not start work")

endmodule

bind slot_pool_alloc_release_enum spa_checker u_spa_checker (.*);

`default_nettype wire

// ===== tb/sv/slot_pool_alloc_release_enum_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot pool allocate, release and enumerate testbench
// Drives allocate, release and enumerate commands through the valid/stall
// input channel with random bursts and gaps, and keeps a pool of its own
// in step with every accepted command. Each result transfer is compared
// field by field with the oldest predicted report. Directed commands come
// first, then a fill to overflow, a release sweep and a random churn phase.
// ----------------------------------------------------------------------------

module slot_pool_alloc_release_enum_tb;

    import spa_pkg::*;

    localparam int         POOL_SLOTS  = SLOTS_DEF;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         TAIL_CYCLES = 300;
    localparam int         HOLD_CYCLES = 400;
    localparam int         HOLD_AFTER  = 60;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_DYNAMIC = 2'd1,
        SLOT_PINNED  = 2'd3
    } t_slot_mark;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_data;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;
    logic      i_stall;

    // Commands waiting to be offered, and whether each must wait for an idle pool.
    t_in_item  cmd_queue [$];
    bit        cmd_wait_idle [$];

    // Reports the pool is expected to send, oldest first.
    t_out_item due_reports [$];

    // Shadow copy of the pool contents.
    t_slot_mark  slot_state [POOL_SLOTS];
    logic [31:0] ent_model [POOL_SLOTS];
    logic [31:0] ent_kind [POOL_SLOTS];
    logic [31:0] ent_x [POOL_SLOTS];
    logic [31:0] ent_y [POOL_SLOTS];
    logic [31:0] ent_z [POOL_SLOTS];
    int          slots_used = 0;

    int fail_count  = 0;
    int items_taken = 0;
    bit in_taken    = 1'b0;

    // Sender burst state and receiver stall state.
    int burst_left  = 1;
    int gap_left    = 0;
    int stall_mode  = 0;
    int stall_phase = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    slot_pool_alloc_release_enum #(
        .SLOTS(POOL_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_stall(i_stall)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A report carrying the stored contents of one slot.
    function automatic t_out_item entry_report(input int s);
        t_out_item r;
        r            = '0;
        r.status     = ST_DONE;
        r.slot       = SLOT_W'(s);
        r.out_model  = ent_model[s];
        r.out_kind   = ent_kind[s];
        r.out_x_bits = ent_x[s];
        r.out_y_bits = ent_y[s];
        r.out_z_bits = ent_z[s];
        return r;
    endfunction

    // Applies one accepted command to the shadow pool and queues its reports.
    task automatic apply_to_pool(input t_in_item c);
        t_out_item r;
        int        found;
        int        last_occ;
        int        idx;
        r = '0;
        case (c.operation)
            OP_ALLOC: begin
                found = -1;
                if (slots_used < POOL_SLOTS) begin
                    for (int i = 0; i < POOL_SLOTS; i++) begin
                        if (found < 0 && slot_state[i] == SLOT_FREE) found = i;
                    end
                end
                if (found >= 0) begin
                    ent_model[found]  = c.model_id;
                    ent_kind[found]   = c.kind_id;
                    ent_x[found]      = c.pos_x_bits;
                    ent_y[found]      = c.pos_y_bits;
                    ent_z[found]      = c.pos_z_bits;
                    slot_state[found] = c.pinned ? SLOT_PINNED : SLOT_DYNAMIC;
                    slots_used++;
                    r             = entry_report(found);
                    r.to_everyone = 1'b1;
                end else begin
                    r.status = ST_FULL;
                end
                r.last = 1'b1;
                due_reports.push_back(r);
            end
            OP_RELEASE: begin
                idx    = c.release_index;
                r.slot = c.release_index[SLOT_W-1:0];
                r.last = 1'b1;
                if (idx < POOL_SLOTS && slot_state[idx] == SLOT_DYNAMIC) begin
                    slot_state[idx] = SLOT_FREE;
                    slots_used--;
                    r.status      = ST_DONE;
                    r.to_everyone = 1'b1;
                end else begin
                    r.status = ST_REFUSED;
                end
                due_reports.push_back(r);
            end
            OP_ENUM: begin
                last_occ = -1;
                for (int i = 0; i < POOL_SLOTS; i++) begin
                    if (slot_state[i] != SLOT_FREE) last_occ = i;
                end
                for (int i = 0; i <= last_occ; i++) begin
                    if (slot_state[i] != SLOT_FREE) begin
                        r           = entry_report(i);
                        r.recipient = c.player_id;
                        r.last      = (i == last_occ);
                        due_reports.push_back(r);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // Field-by-field comparison of one result transfer.
    task automatic check_report(input t_out_item got, input t_out_item want);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            fail_count++;
        end
        if (got.out_model !== want.out_model) begin
            $error("out_model: expected %0d, got %0d", want.out_model, got.out_model);
            fail_count++;
        end
        if (got.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
            fail_count++;
        end
        if (got.out_x_bits !== want.out_x_bits) begin
            $error("out_x_bits: expected %h, got %h", want.out_x_bits, got.out_x_bits);
            fail_count++;
        end
        if (got.out_y_bits !== want.out_y_bits) begin
            $error("out_y_bits: expected %h, got %h", want.out_y_bits, got.out_y_bits);
            fail_count++;
        end
        if (got.out_z_bits !== want.out_z_bits) begin
            $error("out_z_bits: expected %h, got %h", want.out_z_bits, got.out_z_bits);
            fail_count++;
        end
        if (got.to_everyone !== want.to_everyone) begin
            $error("to_everyone: expected %0d, got %0d", want.to_everyone, got.to_everyone);
            fail_count++;
        end
        if (got.recipient !== want.recipient) begin
            $error("recipient: expected %0d, got %0d", want.recipient, got.recipient);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    // A command with every field random; callers override what matters.
    function automatic t_in_item random_cmd();
        t_in_item c;
        c.operation     = 2'($urandom_range(0, 3));
        c.model_id      = $urandom;
        c.kind_id       = $urandom;
        c.pos_x_bits    = $urandom;
        c.pos_y_bits    = $urandom;
        c.pos_z_bits    = $urandom;
        c.pinned        = 1'($urandom_range(0, 1));
        c.release_index = 8'($urandom);
        c.player_id     = 8'($urandom);
        return c;
    endfunction

    function automatic t_in_item alloc_cmd(input logic [31:0] model, input logic [31:0] kind,
                                           input logic [31:0] pos, input logic pin);
        t_in_item c;
        c            = random_cmd();
        c.operation  = OP_ALLOC;
        c.model_id   = model;
        c.kind_id    = kind;
        c.pos_x_bits = pos;
        c.pos_y_bits = ~pos;
        c.pos_z_bits = pos ^ 32'h0F0F_F0F0;
        c.pinned     = pin;
        return c;
    endfunction

    function automatic t_in_item release_cmd(input logic [7:0] index);
        t_in_item c;
        c               = random_cmd();
        c.operation     = OP_RELEASE;
        c.release_index = index;
        return c;
    endfunction

    function automatic t_in_item enum_cmd(input logic [7:0] player);
        t_in_item c;
        c           = random_cmd();
        c.operation = OP_ENUM;
        c.player_id = player;
        return c;
    endfunction

    task automatic queue_cmd(input t_in_item c, input bit wait_idle);
        cmd_queue.push_back(c);
        cmd_wait_idle.push_back(wait_idle);
    endtask

    task automatic build_stimulus();
        t_in_item c;
        int       pick;
        // Directed: empty pool, unused operation, field extremes, refusals.
        queue_cmd(enum_cmd(8'hFF), 1'b0);
        queue_cmd(release_cmd(8'd0), 1'b0);
        c           = random_cmd();
        c.operation = OP_UNUSED;
        queue_cmd(c, 1'b0);
        queue_cmd(alloc_cmd(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0), 1'b0);
        queue_cmd(alloc_cmd(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1), 1'b0);
        queue_cmd(alloc_cmd(32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555, 1'b0), 1'b0);
        queue_cmd(alloc_cmd(32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b1), 1'b0);
        queue_cmd(enum_cmd(8'h00), 1'b0);
        queue_cmd(release_cmd(8'd1), 1'b0);
        queue_cmd(release_cmd(8'd0), 1'b0);
        queue_cmd(release_cmd(8'd0), 1'b0);
        queue_cmd(release_cmd(8'd64), 1'b0);
        queue_cmd(release_cmd(8'd255), 1'b0);
        queue_cmd(release_cmd(8'hAA), 1'b0);
        queue_cmd(alloc_cmd($urandom, $urandom, $urandom, 1'b0), 1'b0);
        queue_cmd(enum_cmd(8'h55), 1'b0);
        queue_cmd(release_cmd(8'd2), 1'b0);
        queue_cmd(enum_cmd(8'hAA), 1'b0);

        // Fill the pool past its size so that allocations overflow.
        for (int i = 0; i < 74; i++) begin
            if (i % 9 == 8) c = enum_cmd(8'($urandom));
            else c = alloc_cmd($urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
            queue_cmd(c, i == 0);
        end
        queue_cmd(enum_cmd(8'($urandom)), 1'b1);

        // Sweep every slot with a release; pinned entries are refused.
        for (int i = 0; i < POOL_SLOTS; i++) begin
            queue_cmd(release_cmd(8'(i)), i == 0);
        end

        // Random churn over a partly filled pool, with some noise.
        for (int i = 0; i < 70; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                c = alloc_cmd($urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
            end else if (pick < 75) begin
                if ($urandom_range(0, 4) == 0) c = release_cmd(8'($urandom));
                else c = release_cmd(8'($urandom_range(0, 31)));
            end else if (pick < 90) begin
                c = enum_cmd(8'($urandom));
            end else begin
                c           = random_cmd();
                c.operation = OP_UNUSED;
            end
            queue_cmd(c, i == 35);
        end
    endtask

    // Monitor: records accepted commands and checks result transfers.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                apply_to_pool(i_data);
                items_taken++;
                in_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (due_reports.size() == 0) begin
                    $error("result transfer with no report due: status %0d, slot %0d",
                           o_data.status, o_data.slot);
                    fail_count++;
                end else begin
                    check_report(o_data, due_reports.pop_front());
                end
            end
        end
    end

    // Driver: offers queued commands in bursts separated by random gaps.
    always @(negedge i_clk) begin : sender
        bit launch;
        launch = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() > 0 &&
                         (!cmd_wait_idle[0] || due_reports.size() == 0)) begin
                launch = 1'b1;
            end
            if (launch) begin
                i_data <= cmd_queue.pop_front();
                void'(cmd_wait_idle.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            i_valid <= launch;
        end
        in_taken = 1'b0;
    end

    // Receiver: stall pattern changes mode now and then, with one long hold-off.
    always @(negedge i_clk) begin : receiver
        bit stall_next;
        stall_next = 1'b0;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            stall_phase++;
            if (!hold_done && items_taken >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                case (stall_mode)
                    1:       stall_next = ($urandom_range(0, 3) == 0);
                    2:       stall_next = ($urandom_range(0, 1) == 0);
                    3:       stall_next = ((stall_phase % 5) < 2);
                    default: stall_next = 1'b0;
                endcase
            end
            if (stall_phase % 97 == 0) stall_mode = $urandom_range(0, 3);
            i_stall <= stall_next;
        end
    end

    // Reset, stimulus and end of run.
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_stall = 1'b0;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_state[i] = SLOT_FREE;
        end
        build_stimulus();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to be taken and every report to arrive.
        while (cmd_queue.size() != 0 || i_valid) @(negedge i_clk);
        while (due_reports.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
